/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define WRV_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define WRV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, also checked across reset
`define WRV_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/wrv_pkg.sv */
// Types and constants for the running variance block
package wrv_pkg;

    localparam int COUNT_BITS  = 20;
    localparam int SAMPLE_BITS = 16;
    localparam int MEAN_W      = 33;
    localparam int DLT_W       = 34;
    localparam int HALF_W      = 17;
    localparam int PROD_W      = 68;
    localparam int INC_W       = 44;
    localparam int SQ_W        = 61;
    localparam int VAR_W       = 40;
    localparam int SD_W        = 24;
    localparam int RAD_W       = 48;
    localparam int FRAC_SHIFT  = 24;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [SQ_W-1:0]       SQ_MAX  = '1;
    localparam logic [VAR_W-1:0]      VAR_MAX = '1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          restart;
    } in_t;

    typedef struct packed {
        logic        [19:0]            total_count;
        logic signed [31:0]            mean_value;
        logic        [39:0]            pop_variance;
        logic        [39:0]            samp_variance;
        logic        [23:0]            std_dev;
        logic signed [SAMPLE_BITS-1:0] min_seen;
        logic signed [SAMPLE_BITS-1:0] max_seen;
        logic                          stats_valid;
        logic                          count_full;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DELTA,
        ST_MDIV,
        ST_DEV2,
        ST_MULLO,
        ST_MULHI,
        ST_ACCUM,
        ST_STATS,
        ST_POPW,
        ST_SAMPW,
        ST_SQW,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic delta;
        logic mean_upd;
        logic dev2;
        logic mul_lo;
        logic mul_hi;
        logic accum;
        logic pop_start;
        logic pop_store;
        logic samp_store;
        logic sqrt_store;
        logic zero_stats;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic upd;
        logic stats_ok;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } sts_t;

endpackage

/* rtl/core/wrv_div.sv */
// Restoring divider, one quotient bit per cycle
module wrv_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [wrv_pkg::SQ_W-1:0]          dividend,
    input  logic [wrv_pkg::COUNT_BITS-1:0]    divisor,
    output logic                              done,
    output logic [wrv_pkg::SQ_W-1:0]          quotient
);
    localparam int STEP_W = $clog2(wrv_pkg::SQ_W + 1);

    logic [wrv_pkg::SQ_W-1:0]       quo_reg, quo_next;
    logic [wrv_pkg::COUNT_BITS:0]   rem_reg, rem_next;
    logic [wrv_pkg::COUNT_BITS-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0]              step_reg, step_next;
    logic                           done_reg, done_next;
    logic [wrv_pkg::COUNT_BITS:0]   part;
    logic [wrv_pkg::COUNT_BITS+1:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        done_next = 1'b0;
        part  = {rem_reg[wrv_pkg::COUNT_BITS-1:0], quo_reg[wrv_pkg::SQ_W-1]};
        trial = {1'b0, part} - {2'b00, dvs_reg};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = STEP_W'(wrv_pkg::SQ_W);
        end else if (step_reg != '0) begin
            if (!trial[wrv_pkg::COUNT_BITS+1]) begin
                rem_next = trial[wrv_pkg::COUNT_BITS:0];
                quo_next = {quo_reg[wrv_pkg::SQ_W-2:0], 1'b1};
            end else begin
                rem_next = part;
                quo_next = {quo_reg[wrv_pkg::SQ_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            done_next = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

/* rtl/core/wrv_sqrt.sv */
// Integer square root, one result bit per cycle
module wrv_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [wrv_pkg::RAD_W-1:0]    radicand,
    output logic                         done,
    output logic [wrv_pkg::SD_W-1:0]     root
);
    localparam int STEP_W = $clog2(wrv_pkg::SD_W + 1);
    localparam int REM_W  = wrv_pkg::SD_W + 3;

    logic [wrv_pkg::RAD_W-1:0] rad_reg, rad_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [wrv_pkg::SD_W-1:0]  root_reg, root_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      done_reg, done_next;
    logic [REM_W-1:0]          part;
    logic [REM_W-1:0]          trial;

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        done_next = 1'b0;
        part  = {rem_reg[REM_W-3:0], rad_reg[wrv_pkg::RAD_W-1 -: 2]};
        trial = {1'b0, root_reg, 2'b01};
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            step_next = STEP_W'(wrv_pkg::SD_W);
        end else if (step_reg != '0) begin
            rad_next = {rad_reg[wrv_pkg::RAD_W-3:0], 2'b00};
            if (part >= trial) begin
                rem_next  = part - trial;
                root_next = {root_reg[wrv_pkg::SD_W-2:0], 1'b1};
            end else begin
                rem_next  = part;
                root_next = {root_reg[wrv_pkg::SD_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            done_next = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

/* rtl/core/wrv_datapath.sv */
// Statistics registers, multiplier steps, shared divider and root unit
module wrv_datapath (
    input  logic            aclk,
    input  logic            aresetn,
    input  wrv_pkg::in_t    s_payload,
    input  logic            m_ready,
    input  wrv_pkg::cmd_t   cmd,
    output wrv_pkg::sts_t   sts,
    output logic            m_valid,
    output wrv_pkg::out_t   m_payload
);
    logic [wrv_pkg::COUNT_BITS-1:0]   cnt_reg, cnt_next;
    logic signed [wrv_pkg::MEAN_W-1:0] mean_reg, mean_next;
    logic [wrv_pkg::SQ_W-1:0]         sq_reg, sq_next;
    logic signed [wrv_pkg::SAMPLE_BITS-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic                             full_reg, full_next;
    logic                             upd_reg, upd_next;
    logic signed [wrv_pkg::SAMPLE_BITS-1:0] x_reg, x_next;
    logic [wrv_pkg::DLT_W-1:0]        dmag_reg, dmag_next, d2mag_reg, d2mag_next;
    logic                             dneg_reg, dneg_next;
    logic [wrv_pkg::PROD_W-1:0]       prod_reg, prod_next;
    logic [wrv_pkg::VAR_W-1:0]        pop_reg, pop_next, samp_reg, samp_next;
    logic [wrv_pkg::SD_W-1:0]         sd_reg, sd_next;
    logic                             mvld_reg, mvld_next;
    wrv_pkg::out_t                    out_reg, out_next;

    logic [wrv_pkg::COUNT_BITS-1:0]   cnt_eff;
    logic signed [wrv_pkg::DLT_W-1:0] xq, diff;
    logic [wrv_pkg::SQ_W:0]           sq_sum;
    logic                             div_start, div_done, sqrt_done;
    logic [wrv_pkg::SQ_W-1:0]         div_a, quo;
    logic [wrv_pkg::COUNT_BITS-1:0]   div_b;
    logic [wrv_pkg::VAR_W-1:0]        quo_sat;
    logic [wrv_pkg::SD_W-1:0]         root;
    logic [wrv_pkg::MEAN_W-1:0]       q_ext;

    assign xq      = {{(wrv_pkg::DLT_W-wrv_pkg::SAMPLE_BITS-16){x_reg[wrv_pkg::SAMPLE_BITS-1]}},
                      x_reg, 16'h0000};
    assign diff    = xq - {mean_reg[wrv_pkg::MEAN_W-1], mean_reg};
    assign cnt_eff = s_payload.restart ? '0 : cnt_reg;
    assign quo_sat = (quo[wrv_pkg::SQ_W-1:wrv_pkg::VAR_W] != '0) ? wrv_pkg::VAR_MAX
                                                                 : quo[wrv_pkg::VAR_W-1:0];
    assign q_ext   = quo[wrv_pkg::MEAN_W-1:0];
    assign sq_sum  = {1'b0, sq_reg}
                   + {{(wrv_pkg::SQ_W+1-wrv_pkg::INC_W){1'b0}},
                      prod_reg[wrv_pkg::PROD_W-1:wrv_pkg::FRAC_SHIFT]};

    assign div_start = cmd.delta | cmd.pop_start | cmd.pop_store;

    always_comb begin
        if (cmd.delta) begin
            div_a = {{(wrv_pkg::SQ_W-wrv_pkg::DLT_W){1'b0}},
                     diff[wrv_pkg::DLT_W-1] ? -diff : diff};
            div_b = cnt_reg + 1'b1;
        end else if (cmd.pop_start) begin
            div_a = sq_reg;
            div_b = cnt_reg;
        end else begin
            div_a = sq_reg;
            div_b = cnt_reg - 1'b1;
        end
    end

    wrv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (quo)
    );

    wrv_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.samp_store),
        .radicand ({quo_sat, 8'h00}),
        .done     (sqrt_done),
        .root     (root)
    );

    always_comb begin
        cnt_next   = cnt_reg;
        mean_next  = mean_reg;
        sq_next    = sq_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        full_next  = full_reg;
        upd_next   = upd_reg;
        x_next     = x_reg;
        dmag_next  = dmag_reg;
        dneg_next  = dneg_reg;
        d2mag_next = d2mag_reg;
        prod_next  = prod_reg;
        pop_next   = pop_reg;
        samp_next  = samp_reg;
        sd_next    = sd_reg;
        mvld_next  = mvld_reg & ~m_ready;
        out_next   = out_reg;

        if (cmd.load) begin
            x_next   = s_payload.sample;
            upd_next = (cnt_eff != wrv_pkg::CNT_MAX);
            if (s_payload.restart) begin
                cnt_next  = '0;
                mean_next = '0;
                sq_next   = '0;
                full_next = 1'b0;
            end
            if (cnt_eff == wrv_pkg::CNT_MAX) begin
                full_next = 1'b1;
            end
        end
        if (cmd.delta) begin
            dneg_next = diff[wrv_pkg::DLT_W-1];
            dmag_next = diff[wrv_pkg::DLT_W-1] ? -diff : diff;
        end
        if (cmd.mean_upd) begin
            mean_next = dneg_reg ? mean_reg - $signed(q_ext) : mean_reg + $signed(q_ext);
        end
        if (cmd.dev2) begin
            d2mag_next = diff[wrv_pkg::DLT_W-1] ? -diff : diff;
        end
        if (cmd.mul_lo) begin
            prod_next = wrv_pkg::PROD_W'(dmag_reg * d2mag_reg[wrv_pkg::HALF_W-1:0]);
        end
        if (cmd.mul_hi) begin
            prod_next = prod_reg
                      + (wrv_pkg::PROD_W'(dmag_reg * d2mag_reg[wrv_pkg::DLT_W-1:wrv_pkg::HALF_W])
                         << wrv_pkg::HALF_W);
        end
        if (cmd.accum) begin
            sq_next  = sq_sum[wrv_pkg::SQ_W] ? wrv_pkg::SQ_MAX : sq_sum[wrv_pkg::SQ_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '0) begin
                lo_next = x_reg;
                hi_next = x_reg;
            end else begin
                if (x_reg < lo_reg) lo_next = x_reg;
                if (x_reg > hi_reg) hi_next = x_reg;
            end
        end
        if (cmd.pop_store)  pop_next  = quo_sat;
        if (cmd.samp_store) samp_next = quo_sat;
        if (cmd.sqrt_store) sd_next   = root;
        if (cmd.zero_stats) begin
            pop_next  = '0;
            samp_next = '0;
            sd_next   = '0;
        end
        if (cmd.out_load) begin
            mvld_next             = 1'b1;
            out_next.total_count   = cnt_reg;
            out_next.mean_value    = mean_reg[31:0];
            out_next.pop_variance  = pop_reg;
            out_next.samp_variance = samp_reg;
            out_next.std_dev       = sd_reg;
            out_next.min_seen      = lo_reg;
            out_next.max_seen      = hi_reg;
            out_next.stats_valid   = (cnt_reg >= 2);
            out_next.count_full    = full_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            mean_reg <= '0;
            sq_reg   <= '0;
            lo_reg   <= '0;
            hi_reg   <= '0;
            full_reg <= 1'b0;
            mvld_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            mean_reg <= mean_next;
            sq_reg   <= sq_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            full_reg <= full_next;
            mvld_reg <= mvld_next;
        end
        upd_reg   <= upd_next;
        x_reg     <= x_next;
        dmag_reg  <= dmag_next;
        dneg_reg  <= dneg_next;
        d2mag_reg <= d2mag_next;
        prod_reg  <= prod_next;
        pop_reg   <= pop_next;
        samp_reg  <= samp_next;
        sd_reg    <= sd_next;
        out_reg   <= out_next;
    end

    assign sts.upd       = upd_reg;
    assign sts.stats_ok  = (cnt_reg >= 2);
    assign sts.div_done  = div_done;
    assign sts.sqrt_done = sqrt_done;
    assign sts.out_free  = ~mvld_reg | m_ready;
    assign m_valid       = mvld_reg;
    assign m_payload     = out_reg;
endmodule

/* rtl/core/wrv_ctrl.sv */
// Sequencer for one sample: update unless the count is full, then divide, divide and root once the count is two or more
module wrv_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  wrv_pkg::sts_t  sts,
    output wrv_pkg::cmd_t  cmd
);
    wrv_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wrv_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            wrv_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = wrv_pkg::ST_CHECK;
                end
            end
            wrv_pkg::ST_CHECK: begin
                // drop the sample when the count is full
                state_next = sts.upd ? wrv_pkg::ST_DELTA : wrv_pkg::ST_STATS;
            end
            wrv_pkg::ST_DELTA: begin
                cmd.delta  = 1'b1;
                state_next = wrv_pkg::ST_MDIV;
            end
            wrv_pkg::ST_MDIV: begin
                if (sts.div_done) begin
                    cmd.mean_upd = 1'b1;
                    state_next   = wrv_pkg::ST_DEV2;
                end
            end
            wrv_pkg::ST_DEV2: begin
                cmd.dev2   = 1'b1;
                state_next = wrv_pkg::ST_MULLO;
            end
            wrv_pkg::ST_MULLO: begin
                cmd.mul_lo = 1'b1;
                state_next = wrv_pkg::ST_MULHI;
            end
            wrv_pkg::ST_MULHI: begin
                cmd.mul_hi = 1'b1;
                state_next = wrv_pkg::ST_ACCUM;
            end
            wrv_pkg::ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = wrv_pkg::ST_STATS;
            end
            wrv_pkg::ST_STATS: begin
                if (sts.stats_ok) begin
                    cmd.pop_start = 1'b1;
                    state_next    = wrv_pkg::ST_POPW;
                end else begin
                    cmd.zero_stats = 1'b1;
                    state_next     = wrv_pkg::ST_OUT;
                end
            end
            wrv_pkg::ST_POPW: begin
                // pop_store also launches the sample-variance divide
                if (sts.div_done) begin
                    cmd.pop_store = 1'b1;
                    state_next    = wrv_pkg::ST_SAMPW;
                end
            end
            wrv_pkg::ST_SAMPW: begin
                // samp_store also launches the root
                if (sts.div_done) begin
                    cmd.samp_store = 1'b1;
                    state_next     = wrv_pkg::ST_SQW;
                end
            end
            wrv_pkg::ST_SQW: begin
                if (sts.sqrt_done) begin
                    cmd.sqrt_store = 1'b1;
                    state_next     = wrv_pkg::ST_OUT;
                end
            end
            wrv_pkg::ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = wrv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wrv_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

/* rtl/core/welford_running_variance.sv */
// Each sample runs the update (a divide on the shared divider) and, once the count is two
// or more, two more divides and a root; a sample dropped on a full count skips the update.
// One sample is in work at a time; the next beat is taken after the result enters the
// output register, which holds until taken.
// Reset (aresetn low, synchronous) clears count, mean, M2, min, max and the full flag.
module welford_running_variance (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  wrv_pkg::in_t   s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output wrv_pkg::out_t  m_payload
);
    wrv_pkg::cmd_t cmd;
    wrv_pkg::sts_t sts;

    wrv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wrv_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_payload (m_payload)
    );
endmodule

/* rtl/core/wrv_checker.sv */
// Port-level checks for the running variance block, bound to the top level
`include "assert_macros.svh"

module wrv_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input wrv_pkg::out_t m_payload
);
    logic stats_on, stats_off, var_zero, count_ok;

    assign stats_on  = m_valid && m_payload.stats_valid;
    assign stats_off = m_valid && !m_payload.stats_valid;
    assign var_zero  = m_payload.pop_variance == '0 && m_payload.samp_variance == '0
                    && m_payload.std_dev == '0;
    assign count_ok  = m_payload.total_count >= 20'd2;

    `WRV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `WRV_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    `WRV_ASSERT_NOW(a_zero_when_invalid, aclk, aresetn, stats_off, var_zero)
    `WRV_ASSERT_NOW(a_valid_count, aclk, aresetn, stats_on, count_ok)
    `WRV_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn, !m_valid)
endmodule

bind welford_running_variance wrv_checker u_wrv_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
